### src/ecg_pkg.sv
// Shared types, constants and helper functions of the ECEF to geodetic converter.
package ecg_pkg;

	localparam int ANGLE_FRAC_BITS = 24;
	localparam int LEN_FRAC        = 12;
	localparam int CORDIC_STEPS    = 30;
	localparam int ANG_W           = 36;
	localparam int DEG_SHIFT       = 54 - ANGLE_FRAC_BITS;

	typedef logic signed [63:0]      len_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef enum logic [1:0] {MSH_0, MSH_30, MSH_40} mul_shift_t;
	typedef enum logic {CM_VEC, CM_ROT} cordic_mode_t;
	typedef enum logic {RM_SQRT, RM_DIV} root_mode_t;

	typedef struct packed {
		logic       start;
		mul_shift_t shift;
	} mul_ctl_t;

	typedef struct packed {
		logic         start;
		cordic_mode_t mode;
	} cordic_ctl_t;

	typedef struct packed {
		logic       start;
		root_mode_t mode;
	} root_ctl_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_POLAR   = 2'd1;
	localparam logic [1:0] ST_NO_CONV = 2'd2;

	localparam logic REG_HEIGHT_TOL = 1'b0;
	localparam logic REG_ITER_LIMIT = 1'b1;

	localparam len_t PI_Q30   = 64'sd3373259426;
	localparam len_t INVK_Q30 = 64'sd652032874;
	localparam len_t E2_Q40   = 64'sd7360548640;
	localparam len_t OME2_Q40 = 64'sd1092151079136;
	localparam len_t A_Q12    = 64'sd26124849152000;
	localparam len_t B_Q12    = 64'sd26037257479148;
	localparam len_t DEG_Q24  = 64'sd961263669;
	localparam len_t INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam len_t LAT_LIM  = 64'sd90 <<< ANGLE_FRAC_BITS;
	localparam len_t LON_LIM  = 64'sd180 <<< ANGLE_FRAC_BITS;

	// Magnitude of a signed 64-bit value as an unsigned word.
	function automatic logic [63:0] mag64(input len_t v);
		logic [63:0] r;
		r = v[63] ? 64'(-v) : 64'(v);
		return r;
	endfunction

	// Arctangent of 2^-i in Q30 radians.
	function automatic ang_t atan_entry(input logic [4:0] i);
		ang_t r;
		case (i)
			5'd0: r = ang_t'(843314856);
			5'd1: r = ang_t'(497837829);
			5'd2: r = ang_t'(263043836);
			5'd3: r = ang_t'(133525158);
			5'd4: r = ang_t'(67021686);
			5'd5: r = ang_t'(33543515);
			5'd6: r = ang_t'(16775850);
			5'd7: r = ang_t'(8388437);
			5'd8: r = ang_t'(4194282);
			5'd9: r = ang_t'(2097149);
			5'd10: r = ang_t'(1048575);
			5'd11: r = ang_t'(524287);
			5'd12: r = ang_t'(262143);
			5'd13: r = ang_t'(131071);
			5'd14: r = ang_t'(65535);
			5'd15: r = ang_t'(32767);
			5'd16: r = ang_t'(16383);
			5'd17: r = ang_t'(8191);
			5'd18: r = ang_t'(4095);
			5'd19: r = ang_t'(2047);
			5'd20: r = ang_t'(1023);
			5'd21: r = ang_t'(511);
			5'd22: r = ang_t'(255);
			5'd23: r = ang_t'(127);
			5'd24: r = ang_t'(63);
			5'd25: r = ang_t'(31);
			5'd26: r = ang_t'(15);
			5'd27: r = ang_t'(7);
			5'd28: r = ang_t'(3);
			5'd29: r = ang_t'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### src/ecg_mul.sv
// Multi-cycle 64x64 signed multiplier with truncating shift and saturation.
module ecg_mul import ecg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_ctl_t ctl,
	input  len_t     a,
	input  len_t     b,
	output logic     done,
	output len_t     result
);

	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	mul_shift_t   sh_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [1:0]   pp_idx_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	len_t         result_q;

	logic [31:0]  op_a, op_b;
	logic [63:0]  pp;
	logic [127:0] placed;
	logic [127:0] shifted;
	logic [63:0]  mag;

	// Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
	always_comb begin
		op_a = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
		op_b = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
		pp   = op_a * op_b;
		case (pp_idx_q)
			2'd0: placed = {64'd0, pp_q};
			2'd1: placed = {32'd0, pp_q, 32'd0};
			2'd2: placed = {32'd0, pp_q, 32'd0};
			default: placed = {pp_q, 64'd0};
		endcase
		case (sh_q)
			MSH_0: shifted = acc_q;
			MSH_30: shifted = acc_q >> 30;
			MSH_40: shifted = acc_q >> 40;
			default: shifted = acc_q;
		endcase
		mag = (|shifted[127:63]) ? 64'(INT64_MAX) : shifted[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				ua_q   <= mag64(a);
				ub_q   <= mag64(b);
				neg_q  <= a[63] ^ b[63];
				sh_q   <= ctl.shift;
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q < 3'd4) begin
					pp_q     <= pp;
					pp_idx_q <= cnt_q[1:0];
				end
				if (cnt_q != 3'd0 && cnt_q != 3'd5) begin
					acc_q <= acc_q + placed;
				end
				if (cnt_q == 3'd5) begin
					result_q <= neg_q ? -len_t'(mag) : len_t'(mag);
					done_q   <= 1'b1;
					busy_q   <= 1'b0;
				end
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/ecg_root.sv
// Bit-serial square root and reciprocal divider sharing one compare-subtract.
module ecg_root import ecg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  root_ctl_t   ctl,
	input  logic [63:0] v_in,
	output logic        done,
	output logic [63:0] result
);

	logic [63:0] rem_q, root_q, bit_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	root_mode_t  mode_q;

	logic [63:0] rsh, lhs, rhs, diff;
	logic        ge;

	// Square root: bit_q walks down by two places. Division: bit_q holds the divisor.
	always_comb begin
		rsh  = {rem_q[62:0], (cnt_q == 6'd0)};
		lhs  = (mode_q == RM_SQRT) ? rem_q : rsh;
		rhs  = (mode_q == RM_SQRT) ? (root_q + bit_q) : bit_q;
		ge   = (lhs >= rhs);
		diff = lhs - rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				mode_q <= ctl.mode;
				cnt_q  <= '0;
				root_q <= '0;
				busy_q <= 1'b1;
				if (ctl.mode == RM_SQRT) begin
					rem_q <= v_in;
					bit_q <= 64'd1 << 62;
				end else begin
					rem_q <= '0;
					bit_q <= v_in;
				end
			end else if (busy_q) begin
				if (mode_q == RM_SQRT) begin
					if (ge) begin
						rem_q  <= diff;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					rem_q  <= ge ? diff : lhs;
					root_q <= {root_q[62:0], ge};
				end
				if ((mode_q == RM_SQRT && cnt_q == 6'd31) ||
				    (mode_q == RM_DIV && cnt_q == 6'd60)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	assign done   = done_q;
	assign result = root_q;

endmodule

### src/ecg_cordic.sv
// Iterative CORDIC in vectoring mode (with normalization) and rotation mode.
module ecg_cordic import ecg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_ctl_t ctl,
	input  len_t        x_in,
	input  len_t        y_in,
	input  ang_t        z_in,
	output logic        done,
	output len_t        x_out,
	output len_t        y_out,
	output ang_t        ang_out,
	output logic [5:0]  norm_shift
);

	typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

	cstate_t     state_q;
	len_t        x_q, y_q;
	ang_t        ang_q;
	logic [5:0]  sh_q;
	logic [4:0]  i_q;
	logic        rot_q, done_q;

	logic [63:0] ax, ay, m;
	logic        sigma_pos;
	len_t        xs, ys;
	ang_t        t;

	always_comb begin
		ax        = mag64(x_q);
		ay        = mag64(y_q);
		m         = (ax > ay) ? ax : ay;
		sigma_pos = rot_q ? !ang_q[ANG_W-1] : !(y_q > 0);
		xs        = x_q >>> i_q;
		ys        = y_q >>> i_q;
		t         = atan_entry(i_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			rot_q   <= 1'b0;
			i_q     <= '0;
			sh_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (ctl.start) begin
						i_q  <= '0;
						sh_q <= '0;
						if (ctl.mode == CM_ROT) begin
							rot_q   <= 1'b1;
							x_q     <= INVK_Q30;
							y_q     <= '0;
							ang_q   <= z_in;
							state_q <= C_ITER;
						end else begin
							rot_q <= 1'b0;
							if (x_in[63]) begin
								x_q   <= -x_in;
								y_q   <= -y_in;
								ang_q <= y_in[63] ? -ang_t'(PI_Q30) : ang_t'(PI_Q30);
							end else begin
								x_q   <= x_in;
								y_q   <= y_in;
								ang_q <= '0;
							end
							state_q <= C_NORM;
						end
					end
				end
				C_NORM: begin
					if (m == 64'd0) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else if (m < (64'd1 << 57) && sh_q < 6'd62) begin
						x_q  <= x_q <<< 1;
						y_q  <= y_q <<< 1;
						sh_q <= sh_q + 6'd1;
					end else begin
						state_q <= C_ITER;
					end
				end
				C_ITER: begin
					x_q   <= sigma_pos ? x_q - ys : x_q + ys;
					y_q   <= sigma_pos ? y_q + xs : y_q - xs;
					ang_q <= sigma_pos ? ang_q - t : ang_q + t;
					if (i_q == 5'(CORDIC_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						i_q <= i_q + 5'd1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done       = done_q;
	assign x_out      = x_q;
	assign y_out      = y_q;
	assign ang_out    = ang_q;
	assign norm_shift = sh_q;

endmodule

### src/ecef_to_geodetic_converter.sv
// Top level of the WGS84 ECEF to geodetic converter: sequencer, registers and output stage.
//
// One ECEF position (millimetres) goes in per transaction and one result comes
// out: latitude and longitude in degrees times 2^24, ellipsoidal height in
// millimetres and a status (ok, on the polar axis, not converged). The block
// works on one position at a time and in_ready is high only while it is idle;
// a finished result sits in an output register, so the next position can be
// taken while the previous result waits for out_ready. A small sequencer
// drives three shared units in turn: a 30-step CORDIC (vectoring with up to
// 57 normalizing shifts, or rotation), a 64x64 multiplier and a bit-serial
// root/divide unit. Setup finds the longitude, the horizontal radius and the
// starting latitude; refinement passes follow, up to the configured limit
// (16 by default), and then the degree conversion. Positions on the polar
// axis skip all of this.
// Configuration writes are taken at any time but are only meant while idle.
module ecef_to_geodetic_converter import ecg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [36:0] ecef_x,
	input  logic signed [36:0] ecef_y,
	input  logic signed [36:0] ecef_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] latitude,
	output logic signed [32:0] longitude,
	output logic signed [36:0] height,
	output logic [1:0]         status
);

	typedef enum logic [4:0] {
		S_IDLE, S_POLAR, S_VEC_LON, S_MUL_P, S_MUL_T, S_ATN, S_SC, S_MUL_SS,
		S_MUL_E2S2, S_SQRT, S_DIV, S_MUL_N, S_MUL_H1, S_MUL_H2, S_MUL_H3,
		S_MUL_D1, S_MUL_D2, S_CHECK, S_DEG_LAT, S_DEG_LON, S_FIN
	} state_t;

	// Configuration registers.
	logic [19:0] tol_q;
	logic [6:0]  lim_q;

	// Sequencer state and working registers.
	state_t      state_q;
	logic        wait_q, first_q;
	logic [6:0]  k_q;
	len_t        xq_q, yq_q, zq_q;
	ang_t        lon_q, lat_q;
	logic [5:0]  sh_q;
	len_t        p_q, den_q, s_q, c_q, tmp_q, w_q, n_q, h_q, prev_q;
	len_t        lat_out_q, lon_out_q;
	logic [1:0]  status_q;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] latitude_q;
	logic signed [32:0] longitude_q;
	logic signed [36:0] height_q;
	logic [1:0]         status_out_q;

	// Shared unit hookup.
	mul_ctl_t    mul_ctl;
	len_t        mul_a, mul_b, mul_res;
	logic        mul_done, is_mul;
	cordic_ctl_t cor_ctl;
	len_t        cor_x_in, cor_y_in, cor_x, cor_y;
	ang_t        cor_z_in, cor_ang;
	logic [5:0]  cor_sh;
	logic        cor_done, is_cor;
	root_ctl_t   root_ctl;
	logic [63:0] root_v, root_res;
	logic        root_done, is_root;

	logic        in_fire, polar_in;
	len_t        in_xq, in_yq, in_zq;
	len_t        arg_diff;
	logic [30:0] arg;
	logic        den_neg;
	logic [63:0] ad, ad_scaled, tol_scaled;
	logic [6:0]  lim_eff;
	logic [63:0] deg_mag, deg_rnd, deg_v;
	len_t        deg_lat, deg_lon;
	len_t        h_abs, h_rnd;
	logic signed [36:0] h_out;
	logic signed [31:0] lat_clamped;
	logic signed [32:0] lon_clamped;
	logic        out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign polar_in = (ecef_x == '0) && (ecef_y == '0);
	assign in_xq    = {{15{ecef_x[36]}}, ecef_x, 12'd0};
	assign in_yq    = {{15{ecef_y[36]}}, ecef_y, 12'd0};
	assign in_zq    = {{15{ecef_z[36]}}, ecef_z, 12'd0};

	// Operand selection for the shared units, driven by the sequencer state.
	always_comb begin
		is_mul        = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		mul_ctl.shift = MSH_30;
		is_cor        = 1'b0;
		cor_ctl.mode  = CM_VEC;
		cor_x_in      = '0;
		cor_y_in      = '0;
		cor_z_in      = '0;
		is_root       = 1'b0;
		root_ctl.mode = RM_SQRT;
		root_v        = '0;
		den_neg       = den_q[63];
		arg_diff      = (64'sd1 <<< 30) - tmp_q;
		if (arg_diff[63]) begin
			arg = '0;
		end else if (arg_diff > (64'sd1 <<< 30)) begin
			arg = 31'd1 << 30;
		end else begin
			arg = arg_diff[30:0];
		end
		case (state_q)
			S_VEC_LON: begin
				is_cor   = 1'b1;
				cor_x_in = xq_q;
				cor_y_in = yq_q;
			end
			S_ATN: begin
				// Arctangent of z over the denominator, kept within a half turn.
				is_cor   = 1'b1;
				cor_x_in = den_neg ? -den_q : den_q;
				cor_y_in = den_neg ? -zq_q : zq_q;
			end
			S_SC: begin
				is_cor       = 1'b1;
				cor_ctl.mode = CM_ROT;
				cor_z_in     = lat_q;
			end
			S_MUL_P: begin
				is_mul = 1'b1;
				mul_a  = tmp_q;
				mul_b  = INVK_Q30;
			end
			S_MUL_T: begin
				is_mul        = 1'b1;
				mul_a         = OME2_Q40;
				mul_b         = p_q;
				mul_ctl.shift = MSH_40;
			end
			S_MUL_SS: begin
				is_mul = 1'b1;
				mul_a  = s_q;
				mul_b  = s_q;
			end
			S_MUL_E2S2: begin
				is_mul        = 1'b1;
				mul_a         = E2_Q40;
				mul_b         = tmp_q;
				mul_ctl.shift = MSH_40;
			end
			S_SQRT: begin
				is_root = 1'b1;
				root_v  = {3'd0, arg, 30'd0};
			end
			S_DIV: begin
				is_root       = 1'b1;
				root_ctl.mode = RM_DIV;
				root_v        = 64'(w_q);
			end
			S_MUL_N: begin
				is_mul = 1'b1;
				mul_a  = A_Q12;
				mul_b  = tmp_q;
			end
			S_MUL_H1: begin
				is_mul = 1'b1;
				mul_a  = p_q;
				mul_b  = c_q;
			end
			S_MUL_H2: begin
				is_mul = 1'b1;
				mul_a  = zq_q;
				mul_b  = s_q;
			end
			S_MUL_H3: begin
				is_mul = 1'b1;
				mul_a  = A_Q12;
				mul_b  = w_q;
			end
			S_MUL_D1: begin
				is_mul        = 1'b1;
				mul_a         = n_q;
				mul_b         = E2_Q40;
				mul_ctl.shift = MSH_40;
			end
			S_MUL_D2: begin
				is_mul = 1'b1;
				mul_a  = tmp_q;
				mul_b  = c_q;
			end
			S_DEG_LAT: begin
				is_mul        = 1'b1;
				mul_a         = len_t'(lat_q);
				mul_b         = DEG_Q24;
				mul_ctl.shift = MSH_0;
			end
			S_DEG_LON: begin
				is_mul        = 1'b1;
				mul_a         = len_t'(lon_q);
				mul_b         = DEG_Q24;
				mul_ctl.shift = MSH_0;
			end
			default: begin
			end
		endcase
		mul_ctl.start  = is_mul && !wait_q;
		cor_ctl.start  = is_cor && !wait_q;
		root_ctl.start = is_root && !wait_q;
	end

	// Convergence test: |h - previous h| * 1000 against tolerance * 4096, modulo 2^64.
	always_comb begin
		ad         = mag64(h_q - prev_q);
		ad_scaled  = (ad << 10) - (ad << 4) - (ad << 3);
		tol_scaled = {32'd0, tol_q, 12'd0};
		lim_eff    = (lim_q == 7'd0) ? 7'd1 : lim_q;
	end

	// Radians to degrees: rounded to nearest, clamped, then signed.
	always_comb begin
		deg_mag = mag64(mul_res);
		deg_rnd = deg_mag + (64'd1 << (DEG_SHIFT - 1));
		deg_v   = deg_rnd >> DEG_SHIFT;
		deg_lat = (deg_v > 64'(LAT_LIM)) ? LAT_LIM : len_t'(deg_v);
		deg_lon = (deg_v > 64'(LON_LIM)) ? LON_LIM : len_t'(deg_v);
		if (lat_q[ANG_W-1]) begin
			deg_lat = -deg_lat;
		end
		if (lon_q[ANG_W-1]) begin
			deg_lon = -deg_lon;
		end
	end

	// Output formatting: height rounding and field-width clamps.
	always_comb begin
		h_abs = len_t'(mag64(h_q)) + (64'sd1 <<< (LEN_FRAC - 1));
		h_rnd = h_q[63] ? -(len_t'(64'(h_abs) >> LEN_FRAC)) : (h_abs >>> LEN_FRAC);
		if (h_rnd < -(64'sd1 <<< 36)) begin
			h_out = {1'b1, 36'd0};
		end else if (h_rnd > ((64'sd1 <<< 36) - 64'sd1)) begin
			h_out = {1'b0, {36{1'b1}}};
		end else begin
			h_out = h_rnd[36:0];
		end
		if (lat_out_q < -(64'sd1 <<< 31)) begin
			lat_clamped = {1'b1, 31'd0};
		end else if (lat_out_q > ((64'sd1 <<< 31) - 64'sd1)) begin
			lat_clamped = {1'b0, {31{1'b1}}};
		end else begin
			lat_clamped = lat_out_q[31:0];
		end
		if (lon_out_q < -(64'sd1 <<< 32)) begin
			lon_clamped = {1'b1, 32'd0};
		end else if (lon_out_q > ((64'sd1 <<< 32) - 64'sd1)) begin
			lon_clamped = {1'b0, {32{1'b1}}};
		end else begin
			lon_clamped = lon_out_q[32:0];
		end
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 20'd1;
			lim_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEIGHT_TOL: tol_q <= cfg_data;
				REG_ITER_LIMIT: lim_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer. Each unit state launches its unit once, then waits for done
	// and stores the result before moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wait_q   <= 1'b0;
			first_q  <= 1'b0;
			k_q      <= '0;
			status_q <= ST_NO_CONV;
		end else begin
			if (cor_ctl.start || mul_ctl.start || root_ctl.start) begin
				wait_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						xq_q     <= in_xq;
						yq_q     <= in_yq;
						zq_q     <= in_zq;
						k_q      <= '0;
						prev_q   <= '0;
						h_q      <= '0;
						status_q <= ST_NO_CONV;
						wait_q   <= 1'b0;
						state_q  <= polar_in ? S_POLAR : S_VEC_LON;
					end
				end
				S_POLAR: begin
					// On the polar axis the height is measured from the pole.
					h_q       <= len_t'(mag64(zq_q)) - B_Q12;
					lat_out_q <= zq_q[63] ? -LAT_LIM : LAT_LIM;
					lon_out_q <= '0;
					status_q  <= ST_POLAR;
					state_q   <= S_FIN;
				end
				S_VEC_LON: begin
					if (cor_done) begin
						lon_q   <= cor_ang;
						tmp_q   <= cor_x;
						sh_q    <= cor_sh;
						wait_q  <= 1'b0;
						state_q <= S_MUL_P;
					end
				end
				S_MUL_P: begin
					if (mul_done) begin
						p_q     <= mul_res >>> sh_q;
						wait_q  <= 1'b0;
						state_q <= S_MUL_T;
					end
				end
				S_MUL_T: begin
					if (mul_done) begin
						den_q   <= mul_res;
						first_q <= 1'b1;
						wait_q  <= 1'b0;
						state_q <= S_ATN;
					end
				end
				S_ATN: begin
					if (cor_done) begin
						lat_q   <= cor_ang;
						first_q <= 1'b0;
						wait_q  <= 1'b0;
						state_q <= first_q ? S_SC : S_CHECK;
					end
				end
				S_SC: begin
					if (cor_done) begin
						s_q     <= cor_y;
						c_q     <= cor_x;
						wait_q  <= 1'b0;
						state_q <= S_MUL_SS;
					end
				end
				S_MUL_SS: begin
					if (mul_done) begin
						tmp_q   <= mul_res;
						wait_q  <= 1'b0;
						state_q <= S_MUL_E2S2;
					end
				end
				S_MUL_E2S2: begin
					if (mul_done) begin
						tmp_q   <= mul_res;
						wait_q  <= 1'b0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (root_done) begin
						w_q     <= (root_res == 64'd0) ? 64'sd1 : len_t'(root_res);
						wait_q  <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (root_done) begin
						tmp_q   <= len_t'(root_res);
						wait_q  <= 1'b0;
						state_q <= S_MUL_N;
					end
				end
				S_MUL_N: begin
					if (mul_done) begin
						n_q     <= mul_res;
						wait_q  <= 1'b0;
						state_q <= S_MUL_H1;
					end
				end
				S_MUL_H1: begin
					if (mul_done) begin
						h_q     <= mul_res;
						wait_q  <= 1'b0;
						state_q <= S_MUL_H2;
					end
				end
				S_MUL_H2: begin
					if (mul_done) begin
						h_q     <= h_q + mul_res;
						wait_q  <= 1'b0;
						state_q <= S_MUL_H3;
					end
				end
				S_MUL_H3: begin
					if (mul_done) begin
						h_q     <= h_q - mul_res;
						wait_q  <= 1'b0;
						state_q <= S_MUL_D1;
					end
				end
				S_MUL_D1: begin
					if (mul_done) begin
						tmp_q   <= mul_res;
						wait_q  <= 1'b0;
						state_q <= S_MUL_D2;
					end
				end
				S_MUL_D2: begin
					if (mul_done) begin
						den_q   <= p_q - mul_res;
						wait_q  <= 1'b0;
						state_q <= S_ATN;
					end
				end
				S_CHECK: begin
					if (ad_scaled <= tol_scaled) begin
						status_q <= ST_OK;
						state_q  <= S_DEG_LAT;
					end else begin
						prev_q <= h_q;
						if (({1'b0, k_q} + 8'd1) >= {1'b0, lim_eff}) begin
							status_q <= ST_NO_CONV;
							state_q  <= S_DEG_LAT;
						end else begin
							k_q     <= k_q + 7'd1;
							state_q <= S_SC;
						end
					end
				end
				S_DEG_LAT: begin
					if (mul_done) begin
						lat_out_q <= deg_lat;
						wait_q    <= 1'b0;
						state_q   <= S_DEG_LON;
					end
				end
				S_DEG_LON: begin
					if (mul_done) begin
						lon_out_q <= deg_lon;
						wait_q    <= 1'b0;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: holds one finished result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			latitude_q   <= lat_clamped;
			longitude_q  <= lon_clamped;
			height_q     <= h_out;
			status_out_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign latitude  = latitude_q;
	assign longitude = longitude_q;
	assign height    = height_q;
	assign status    = status_out_q;

	ecg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	ecg_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cor_ctl),
		.x_in       (cor_x_in),
		.y_in       (cor_y_in),
		.z_in       (cor_z_in),
		.done       (cor_done),
		.x_out      (cor_x),
		.y_out      (cor_y),
		.ang_out    (cor_ang),
		.norm_shift (cor_sh)
	);

	ecg_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (root_ctl),
		.v_in   (root_v),
		.done   (root_done),
		.result (root_res)
	);

endmodule

### src/ecg_checker.sv
// Port-level assertions for the ECEF to geodetic converter and their bind.
module ecg_checker import ecg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] latitude,
	input logic signed [32:0] longitude,
	input logic [1:0]         status
);

	// A transaction starts a multi-cycle computation, so the block is busy next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an input transaction");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_POLAR || status == ST_NO_CONV))
		else $error("undefined status code on the output");

	a_polar_longitude: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_POLAR |-> longitude == '0)
		else $error("polar-axis result carries a nonzero longitude");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(latitude) && $stable(status))
		else $error("stalled result changed or was dropped");

endmodule

bind ecef_to_geodetic_converter ecg_checker u_ecg_checker (.*);

### tb/ecef_to_geodetic_converter_tb.sv
// Self-checking testbench of the ECEF to geodetic converter with a bit-exact fix predictor.
module ecef_to_geodetic_converter_tb;
	import ecg_pkg::*;

	typedef logic signed [63:0] s64_t;
	typedef logic [63:0] u64_t;

	// One geodetic fix as the block reports it.
	typedef struct packed {
		logic signed [31:0] lat;
		logic signed [32:0] lon;
		logic signed [36:0] hgt;
		logic [1:0]         st;
	} fix_t;

	// One row of the directed table. Where known is set, the fix is typed in.
	typedef struct packed {
		logic signed [36:0] x;
		logic signed [36:0] y;
		logic signed [36:0] z;
		logic               known;
		fix_t               want;
	} row_t;

	localparam logic signed [36:0] P_MAX = 37'sh0F_FFFF_FFFF;
	localparam logic signed [36:0] P_MIN = 37'sh10_0000_0000;
	localparam logic signed [31:0] NORTH = 32'sd1509949440;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int NUM_PHASES = 7;

	localparam row_t DIRECTED [18] = '{
		// Polar axis rows have fixed results: latitude is +-90 degrees and the
		// height is |z| minus the polar radius, rounded to the millimetre.
		'{x: 37'sd0, y: 37'sd0, z: 37'sd0, known: 1'b1,
			want: '{lat: NORTH, lon: 33'sd0, hgt: -37'sd6356752314, st: ST_POLAR}},
		'{x: 37'sd0, y: 37'sd0, z: P_MAX, known: 1'b1,
			want: '{lat: NORTH, lon: 33'sd0, hgt: 37'sd62362724421, st: ST_POLAR}},
		'{x: 37'sd0, y: 37'sd0, z: P_MIN, known: 1'b1,
			want: '{lat: -NORTH, lon: 33'sd0, hgt: 37'sd62362724422, st: ST_POLAR}},
		'{x: 37'sd0, y: 37'sd0, z: -37'sd1, known: 1'b1,
			want: '{lat: -NORTH, lon: 33'sd0, hgt: -37'sd6356752313, st: ST_POLAR}},
		'{x: 37'sd6378137000, y: 37'sd0, z: 37'sd0, known: 1'b0, want: '0},
		'{x: -37'sd6378137000, y: 37'sd0, z: 37'sd0, known: 1'b0, want: '0},
		'{x: 37'sd0, y: 37'sd6378137000, z: 37'sd0, known: 1'b0, want: '0},
		'{x: 37'sd0, y: -37'sd6378137000, z: 37'sd0, known: 1'b0, want: '0},
		'{x: P_MAX, y: P_MAX, z: P_MAX, known: 1'b0, want: '0},
		'{x: P_MIN, y: P_MIN, z: P_MIN, known: 1'b0, want: '0},
		'{x: P_MAX, y: P_MIN, z: 37'sd0, known: 1'b0, want: '0},
		'{x: 37'sd1, y: 37'sd0, z: 37'sd0, known: 1'b0, want: '0},
		'{x: -37'sd1, y: 37'sd0, z: 37'sd1, known: 1'b0, want: '0},
		'{x: 37'sd1, y: 37'sd1, z: -37'sd1, known: 1'b0, want: '0},
		'{x: -37'sd1, y: 37'sd0, z: 37'sd0, known: 1'b0, want: '0},
		'{x: 37'sd4000000000, y: 37'sd3000000000, z: 37'sd4500000000, known: 1'b0,
			want: '0},
		'{x: -37'sd2694045000, y: -37'sd4293642000, z: 37'sd3857878000, known: 1'b0,
			want: '0},
		'{x: 37'sd100, y: 37'sd0, z: 37'sd6356752314, known: 1'b0, want: '0}
	};

	// Settings walked by the random part: tolerance, pass limit and item count.
	// The last phase runs without any idling.
	localparam int TOL_TAB [NUM_PHASES] = '{1, 0, 1048575, 0, 5000, 1048575, 1};
	localparam int LIM_TAB [NUM_PHASES] = '{16, 3, 127, 0, 64, 1, 16};
	localparam int CNT_TAB [NUM_PHASES] = '{90, 40, 6, 30, 50, 24, 50};

	localparam s64_t ATAN_Q30 [30] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7, 3, 1
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [19:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [36:0] ecef_x;
	logic signed [36:0] ecef_y;
	logic signed [36:0] ecef_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] latitude;
	logic signed [32:0] longitude;
	logic signed [36:0] height;
	logic [1:0]         status;

	// Predictor copy of the two configuration registers.
	logic [19:0] tol_reg;
	logic [6:0]  lim_reg;

	fix_t pending_fixes[$];
	int   errors;
	int   fixes_seen;
	bit   quiet;

	ecef_to_geodetic_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ecef_x    (ecef_x),
		.ecef_y    (ecef_y),
		.ecef_z    (ecef_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.latitude  (latitude),
		.longitude (longitude),
		.height    (height),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Fixed-point predictor. Every scaled product is taken on magnitudes, shifted
	// down with truncation and saturated to the positive 64-bit range; the
	// CORDIC shifts are arithmetic, so they round toward minus infinity.
	// ------------------------------------------------------------------

	function automatic u64_t magnitude(input s64_t v);
		return v[63] ? u64_t'(-v) : u64_t'(v);
	endfunction

	function automatic s64_t scaled_product(input s64_t a, input s64_t b, input int sh);
		logic [127:0] full;
		logic [127:0] shifted;
		u64_t         r;
		full = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		shifted = full >> sh;
		r = (shifted[127:64] != 0) ? '1 : shifted[63:0];
		if (r > 64'h7FFF_FFFF_FFFF_FFFF)
			r = 64'h7FFF_FFFF_FFFF_FFFF;
		return (a[63] != b[63]) ? -s64_t'(r) : s64_t'(r);
	endfunction

	function automatic u64_t int_root(input u64_t v);
		u64_t r;
		u64_t bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt >>= 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return r;
	endfunction

	// Vectoring CORDIC: returns the magnitude of (x, y) and its angle in Q30.
	function automatic s64_t polar_of(input s64_t x, input s64_t y, output s64_t ang);
		s64_t a;
		s64_t nx;
		s64_t ny;
		u64_t m;
		int   sh;
		a = 0;
		sh = 0;
		if (x < 0) begin
			a = (y >= 0) ? PI_Q30 : -PI_Q30;
			x = -x;
			y = -y;
		end
		m = (magnitude(x) > magnitude(y)) ? magnitude(x) : magnitude(y);
		if (m == 0) begin
			ang = a;
			return 0;
		end
		while (m < (64'd1 << 57) && sh < 62) begin
			m <<= 1;
			sh++;
		end
		x = x <<< sh;
		y = y <<< sh;
		for (int i = 0; i < 30; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				a += ATAN_Q30[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				a -= ATAN_Q30[i];
			end
			x = nx;
			y = ny;
		end
		ang = a;
		return scaled_product(x, INVK_Q30, 30) >>> sh;
	endfunction

	// Arctangent of num/den; a negative denominator is folded into the numerator.
	function automatic s64_t ratio_angle(input s64_t num, input s64_t den);
		s64_t a;
		s64_t unused;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		unused = polar_of(den, num, a);
		return a;
	endfunction

	function automatic void sine_cosine(input s64_t z, output s64_t s, output s64_t c);
		s64_t x;
		s64_t y;
		s64_t nx;
		s64_t ny;
		x = INVK_Q30;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ATAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ATAN_Q30[i];
			end
			x = nx;
			y = ny;
		end
		s = y;
		c = x;
	endfunction

	// Q30 radians to degrees times 2^24, rounded half away from zero and clamped.
	function automatic s64_t degrees_of(input s64_t r, input s64_t lim);
		u64_t v;
		v = (magnitude(r) * u64_t'(DEG_Q24) + (64'd1 << (DEG_SHIFT - 1))) >> DEG_SHIFT;
		if (v > u64_t'(lim))
			v = u64_t'(lim);
		return r < 0 ? -s64_t'(v) : s64_t'(v);
	endfunction

	function automatic s64_t millimetres_of(input s64_t h);
		s64_t v;
		v = (h >= 0) ? ((h + 2048) >>> LEN_FRAC) : -((-h + 2048) >>> LEN_FRAC);
		if (v < -(64'sd1 <<< 36))
			v = -(64'sd1 <<< 36);
		if (v > (64'sd1 <<< 36) - 1)
			v = (64'sd1 <<< 36) - 1;
		return v;
	endfunction

	function automatic fix_t predict_fix(input logic signed [36:0] px,
			input logic signed [36:0] py, input logic signed [36:0] pz);
		s64_t xq, yq, zq, lon, lat, h, p, prev, lat_out, lon_out;
		s64_t s, c, e2s2, w, n, den, arg;
		u64_t invw;
		int   lim;
		fix_t f;
		xq = s64_t'(px) * 4096;
		yq = s64_t'(py) * 4096;
		zq = s64_t'(pz) * 4096;
		lon = 0;
		lat = 0;
		h = 0;
		prev = 0;
		f.st = ST_NO_CONV;
		if (px == 0 && py == 0) begin
			f.st = ST_POLAR;
			lat_out = (pz >= 0) ? LAT_LIM : -LAT_LIM;
			lon_out = 0;
			h = (zq < 0 ? -zq : zq) - B_Q12;
		end else begin
			p = polar_of(xq, yq, lon);
			lat = ratio_angle(zq, scaled_product(OME2_Q40, p, 40));
			lim = (lim_reg == 0) ? 1 : int'(lim_reg);
			for (int k = 0; k < lim; k++) begin
				sine_cosine(lat, s, c);
				e2s2 = scaled_product(E2_Q40, scaled_product(s, s, 30), 40);
				arg = (64'sd1 <<< 30) - e2s2;
				if (arg < 0)
					arg = 0;
				if (arg > (64'sd1 <<< 30))
					arg = 64'sd1 <<< 30;
				w = s64_t'(int_root(u64_t'(arg) << 30));
				if (w == 0)
					w = 1;
				invw = (64'd1 << 60) / u64_t'(w);
				n = scaled_product(A_Q12, s64_t'(invw), 30);
				h = scaled_product(p, c, 30) + scaled_product(zq, s, 30)
					- scaled_product(A_Q12, w, 30);
				den = p - scaled_product(scaled_product(n, E2_Q40, 40), c, 30);
				lat = ratio_angle(zq, den);
				if (magnitude(h - prev) * 1000 <= u64_t'(tol_reg) * 4096) begin
					f.st = ST_OK;
					break;
				end
				prev = h;
			end
			lat_out = degrees_of(lat, LAT_LIM);
			lon_out = degrees_of(lon, LON_LIM);
		end
		// Both angle limits already sit inside the field ranges.
		f.lat = lat_out[31:0];
		f.lon = lon_out[32:0];
		f.hgt = millimetres_of(h);
		return f;
	endfunction

	// ------------------------------------------------------------------
	// Driving tasks. Every block input is assigned at a rising edge with
	// nonblocking assignments, and each task returns at a rising edge.
	// ------------------------------------------------------------------

	task automatic write_reg(input logic idx, input logic [19:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEIGHT_TOL)
			tol_reg = val;
		else
			lim_reg = val[6:0];
		@(posedge clk);
	endtask

	// Offers one position, optionally after an idle gap, and records the
	// predicted fix (or the typed-in one) once the transaction is accepted.
	task automatic send_position(input logic signed [36:0] px, input logic signed [36:0] py,
			input logic signed [36:0] pz, input bit known, input fix_t want);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ecef_x   <= px;
		ecef_y   <= py;
		ecef_z   <= pz;
		do
			@(posedge clk);
		while (!in_ready);
		pending_fixes.push_back(known ? want : predict_fix(px, py, pz));
	endtask

	// Returns a random coordinate: mostly Earth-sized, some tiny, some spanning
	// the whole field so that every bit toggles.
	function automatic logic signed [36:0] rand_coord(input int kind);
		s64_t v;
		v = s64_t'($signed({$urandom, $urandom}));
		case (kind)
			0: return v[36:0];
			1: return 37'(int'($urandom_range(0, 8191)) - 4096);
			default: return 37'(v >>> 30);
		endcase
	endfunction

	task automatic wait_drained;
		while (pending_fixes.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: checks each accepted transaction against the oldest
	// expected fix, and paces out_ready with random stalls plus one long
	// hold-off that fills the block and stalls its input.
	// ------------------------------------------------------------------
	int stall_left;
	int hold_left;
	bit hold_done;

	always @(posedge clk) begin
		fix_t exp_fix;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				fixes_seen++;
				if (pending_fixes.size() == 0) begin
					errors++;
					$display("%0t: unexpected fix lat=%0d lon=%0d h=%0d st=%0d", $time,
						latitude, longitude, height, status);
				end else begin
					exp_fix = pending_fixes.pop_front();
					if (latitude !== exp_fix.lat) begin
						errors++;
						$display("%0t: latitude expected %0d actual %0d", $time,
							exp_fix.lat, latitude);
					end
					if (longitude !== exp_fix.lon) begin
						errors++;
						$display("%0t: longitude expected %0d actual %0d", $time,
							exp_fix.lon, longitude);
					end
					if (height !== exp_fix.hgt) begin
						errors++;
						$display("%0t: height expected %0d actual %0d", $time,
							exp_fix.hgt, height);
					end
					if (status !== exp_fix.st) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time,
							exp_fix.st, status);
					end
				end
			end
			// The long hold-off starts once, early in the random part.
			if (fixes_seen == 30 && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!quiet && stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 8);
			end
		end
	end

	// Ends the run when no transaction has happened on either side for too long.
	int idle_cycles;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, the directed table at reset settings, then
	// random phases, each one written in while the block is idle.
	// ------------------------------------------------------------------
	initial begin
		int kind;
		logic signed [36:0] rx, ry, rz;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_HEIGHT_TOL;
		cfg_data   = '0;
		in_valid   = 1'b0;
		ecef_x     = '0;
		ecef_y     = '0;
		ecef_z     = '0;
		out_ready  = 1'b0;
		tol_reg    = 20'd1;
		lim_reg    = 7'd16;
		errors     = 0;
		fixes_seen = 0;
		quiet      = 1'b0;
		stall_left = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_position(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z,
				DIRECTED[i].known, DIRECTED[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			// The sender pauses here until every fix so far has come back.
			in_valid <= 1'b0;
			wait_drained();
			write_reg(REG_HEIGHT_TOL, 20'(TOL_TAB[ph]));
			write_reg(REG_ITER_LIMIT, 20'(LIM_TAB[ph]));
			quiet = (ph == NUM_PHASES - 1);
			for (int n = 0; n < CNT_TAB[ph]; n++) begin
				kind = $urandom_range(0, 19);
				if (kind < 3) begin
					rx = rand_coord(0);
					ry = rand_coord(0);
					rz = rand_coord(0);
				end else if (kind < 5) begin
					rx = rand_coord(1);
					ry = rand_coord(1);
					rz = rand_coord(1);
				end else if (kind < 7) begin
					// Polar axis, or a point in the x-z plane (y is zero).
					rx = (kind == 5) ? 37'sd0 : rand_coord(2);
					ry = 37'sd0;
					rz = rand_coord($urandom_range(0, 2));
				end else begin
					rx = rand_coord(2);
					ry = rand_coord(2);
					rz = rand_coord(2);
				end
				send_position(rx, ry, rz, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
